[sv/fmcu_pkg.sv]
// Package with shared codes and sizes of the lock manager.
package fmcu_pkg;
   localparam int THREADS_DEF = 32;
   localparam int MUTEXES_DEF = 16;
   localparam int CONDS_DEF = 16;
   localparam int TID_W = 5;
   localparam int MID_W = 4;
   localparam int CID_W = 4;

   typedef enum logic [2:0] {
      FN_LOCK = 3'd0, FN_TRYLOCK = 3'd1, FN_UNLOCK = 3'd2,
      FN_WAIT = 3'd3, FN_SIGNAL = 3'd4, FN_BCAST = 3'd5
   } func_type;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_BLOCKED = 2'd1;
   localparam logic [1:0] ST_BUSY = 2'd2;
   localparam logic [1:0] ST_MISUSE = 2'd3;
endpackage

[sv/fifo_mutex_condvar_unit_top.sv]
// Top level of the lock manager: request decode, table memories and result register.
// Each request passes through a table read, a link read and a modify-write step.
// The link read needs the heads of the table read; a new request waits for the write.
// The result is registered by the write step; a request is taken only when no result waits
// or the waiting one leaves in that same cycle.
// Reset clears the valid, held and blocked bits in flip-flops at once; no sweep.
module fifo_mutex_condvar_unit_top #(
   parameter int THREADS = fmcu_pkg::THREADS_DEF,
   parameter int MUTEXES = fmcu_pkg::MUTEXES_DEF,
   parameter int CONDS = fmcu_pkg::CONDS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // func[2:0], thread_id[7:3], mutex_id[11:8], cond_id[15:12]
   input  logic [15:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status[1:0], woken_valid[2], woken_thread[7:3]
   output logic [7:0] rsp_tdata
);
   localparam int TW = fmcu_pkg::TID_W;
   localparam int MW = fmcu_pkg::MID_W;
   localparam int CW = fmcu_pkg::CID_W;

   typedef enum logic [1:0] {
      PH_IDLE, PH_LINK, PH_WRITE
   } phase_type;

   // Memories: next links, lock head/tail, cond head/tail.
   logic [TW-1:0] next_mem [THREADS];
   logic [TW-1:0] lhead_mem [MUTEXES];
   logic [TW-1:0] ltail_mem [MUTEXES];
   logic [TW-1:0] chead_mem [CONDS];
   logic [TW-1:0] ctail_mem [CONDS];
   // Flag and owner state in flip-flops.
   logic [MUTEXES-1:0] held_ff, lne_ff;
   logic [TW-1:0] owner_ff [MUTEXES];
   logic [CONDS-1:0] cne_ff;
   logic [THREADS-1:0] blk_ff;

   phase_type phase_ff;
   logic [2:0] f_ff;
   logic [TW-1:0] t_ff;
   logic [MW-1:0] m_ff;
   logic [CW-1:0] c_ff;
   logic [TW-1:0] lh_q, lt_q, ch_q, ct_q, nx_lh_q, nx_ch_q;
   logic rv_ff;
   logic [7:0] rd_ff;

   assign req_tready = (phase_ff == PH_IDLE) && (!rv_ff || rsp_tready);
   wire acc = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;

   wire [2:0] a_f = req_tdata[2:0];
   wire [TW-1:0] a_t = req_tdata[7:3];
   wire [MW-1:0] a_m = req_tdata[11:8];
   wire [CW-1:0] a_c = req_tdata[15:12];

   // Read cycle: fetch heads and tails of the addressed queues.
   // Link cycle: fetch the links behind both heads read the cycle before.
   always_ff @(posedge clock) begin
      if (acc) begin
         f_ff <= a_f; t_ff <= a_t; m_ff <= a_m; c_ff <= a_c;
         lh_q <= lhead_mem[a_m]; lt_q <= ltail_mem[a_m];
         ch_q <= chead_mem[a_c]; ct_q <= ctail_mem[a_c];
      end
      if (phase_ff == PH_LINK) begin
         nx_lh_q <= next_mem[lh_q];
         nx_ch_q <= next_mem[ch_q];
      end
   end

   // Modify: decide the request.
   logic ok, owns, lne, cne, woke;
   logic [1:0] st;
   logic [TW-1:0] wk;
   logic wr_next, wr_lh, wr_lt, wr_ch, wr_ct;
   logic [TW-1:0] next_a, next_d, lh_d, lt_d, ch_d, ct_d;
   logic rel, set_lne, clr_lne, set_cne, clr_cne, take, blk_set;
   logic [THREADS-1:0] blk_in;

   always_comb begin
      ok = (f_ff <= fmcu_pkg::FN_BCAST) && (32'(t_ff) < THREADS) && (32'(m_ff) < MUTEXES)
         && (f_ff < fmcu_pkg::FN_WAIT || 32'(c_ff) < CONDS);
      ok = ok && !blk_ff[t_ff];
      owns = held_ff[m_ff] && owner_ff[m_ff] == t_ff;
      lne = lne_ff[m_ff]; cne = cne_ff[c_ff];
      st = fmcu_pkg::ST_MISUSE; woke = 1'b0; wk = '0;
      wr_next = 1'b0; wr_lh = 1'b0; wr_lt = 1'b0; wr_ch = 1'b0; wr_ct = 1'b0;
      next_a = '0; next_d = '0; lh_d = '0; lt_d = '0; ch_d = '0; ct_d = '0;
      rel = 1'b0; set_lne = 1'b0; clr_lne = 1'b0; set_cne = 1'b0; clr_cne = 1'b0;
      take = 1'b0; blk_set = 1'b0;
      blk_in = blk_ff;
      if (ok) begin
         case (fmcu_pkg::func_type'(f_ff))
            fmcu_pkg::FN_LOCK, fmcu_pkg::FN_TRYLOCK: begin
               if (!held_ff[m_ff]) begin
                  take = 1'b1; st = fmcu_pkg::ST_DONE;
               end else if (f_ff == fmcu_pkg::FN_TRYLOCK) begin
                  st = fmcu_pkg::ST_BUSY;
               end else if (!owns) begin
                  if (lne) begin
                     wr_next = 1'b1; next_a = lt_q; next_d = t_ff;
                  end else begin
                     wr_lh = 1'b1; lh_d = t_ff;
                  end
                  wr_lt = 1'b1; lt_d = t_ff; set_lne = 1'b1; blk_set = 1'b1;
                  st = fmcu_pkg::ST_BLOCKED;
               end
            end
            fmcu_pkg::FN_UNLOCK: begin
               if (owns) begin
                  rel = 1'b1; st = fmcu_pkg::ST_DONE;
               end
            end
            fmcu_pkg::FN_WAIT: begin
               if (owns) begin
                  if (cne) begin
                     wr_next = 1'b1; next_a = ct_q; next_d = t_ff;
                  end else begin
                     wr_ch = 1'b1; ch_d = t_ff;
                  end
                  wr_ct = 1'b1; ct_d = t_ff; set_cne = 1'b1; blk_set = 1'b1;
                  rel = 1'b1; st = fmcu_pkg::ST_BLOCKED;
               end
            end
            fmcu_pkg::FN_SIGNAL: begin
               if (!cne) st = fmcu_pkg::ST_DONE;
               else if (owns) begin
                  if (ch_q == ct_q) clr_cne = 1'b1;
                  else begin
                     wr_ch = 1'b1; ch_d = nx_ch_q;
                  end
                  // The head moves to the mutex queue; its own link is left stale.
                  if (lne) begin
                     wr_next = 1'b1; next_a = lt_q; next_d = ch_q;
                  end else begin
                     wr_lh = 1'b1; lh_d = ch_q;
                  end
                  wr_lt = 1'b1; lt_d = ch_q; set_lne = 1'b1;
                  st = fmcu_pkg::ST_DONE;
               end
            end
            fmcu_pkg::FN_BCAST: begin
               if (!cne) st = fmcu_pkg::ST_DONE;
               else if (owns) begin
                  if (lne) begin
                     wr_next = 1'b1; next_a = lt_q; next_d = ch_q;
                  end else begin
                     wr_lh = 1'b1; lh_d = ch_q;
                  end
                  wr_lt = 1'b1; lt_d = ct_q; set_lne = 1'b1; clr_cne = 1'b1;
                  st = fmcu_pkg::ST_DONE;
               end
            end
            default: st = fmcu_pkg::ST_MISUSE;
         endcase
      end
      if (blk_set) blk_in[t_ff] = 1'b1;
      // Release: hand the mutex to the head waiter when one exists.
      if (rel && lne) begin
         woke = 1'b1; wk = lh_q;
         blk_in[lh_q] = 1'b0;
         if (lh_q == lt_q) clr_lne = 1'b1;
         else begin
            wr_lh = 1'b1; lh_d = nx_lh_q;
         end
      end
   end

   // Write cycle: commit memories.
   always_ff @(posedge clock) begin
      if (phase_ff == PH_WRITE) begin
         if (wr_next) next_mem[next_a] <= next_d;
         if (wr_lh) lhead_mem[m_ff] <= lh_d;
         if (wr_lt) ltail_mem[m_ff] <= lt_d;
         if (wr_ch) chead_mem[c_ff] <= ch_d;
         if (wr_ct) ctail_mem[c_ff] <= ct_d;
      end
   end

   // Sequencing, flags and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; rv_ff <= 1'b0;
         held_ff <= '0; lne_ff <= '0; cne_ff <= '0; blk_ff <= '0;
         for (int i = 0; i < MUTEXES; i++) owner_ff[i] <= '0;
      end else begin
         case (phase_ff)
            PH_IDLE: if (acc) phase_ff <= PH_LINK;
            PH_LINK: phase_ff <= PH_WRITE;
            default: phase_ff <= PH_IDLE;
         endcase
         if (phase_ff == PH_WRITE) begin
            rv_ff <= 1'b1;
            rd_ff <= {wk, woke, st};
            blk_ff <= blk_in;
            if (take) begin
               held_ff[m_ff] <= 1'b1; owner_ff[m_ff] <= t_ff;
            end
            if (set_lne) lne_ff[m_ff] <= 1'b1;
            if (set_cne) cne_ff[c_ff] <= 1'b1;
            if (clr_cne) cne_ff[c_ff] <= 1'b0;
            if (rel) begin
               if (lne) begin
                  owner_ff[m_ff] <= lh_q;
                  if (clr_lne) lne_ff[m_ff] <= 1'b0;
               end else begin
                  held_ff[m_ff] <= 1'b0; owner_ff[m_ff] <= '0;
               end
            end
         end else if (rsp_tready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   a_no_back: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> !req_tready) else $error("request taken while one is in flight");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WRITE |=> rv_ff) else $error("result missing after write cycle");
   a_woke_st: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rd_ff[2] |-> rd_ff[1] == 1'b0) else $error("wake with bad status");
endmodule

[tb/tb_fifo_mutex_condvar_unit_top.sv]
// Self-checking testbench for the lock manager: directed table, then random request traffic.
module tb_fifo_mutex_condvar_unit_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT = 32;
   localparam int NM = 16;
   localparam int NC = 16;
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [3:0] cid;
      logic [3:0] mid;
      logic [4:0] tid;
      logic [2:0] fn;
   } request_type;

   typedef struct packed {
      logic [4:0] woken_thread;
      logic       woken_valid;
      logic [1:0] status;
   } grant_type;

   typedef struct {
      request_type req;
      logic        known;
      grant_type   rsp;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [7:0] rsp_tdata;

   fifo_mutex_condvar_unit_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Shadow copy of the lock tables.
   logic       held[NM];
   logic [4:0] owner[NM];
   logic       mq_ne[NM];
   logic [4:0] mq_head[NM];
   logic [4:0] mq_tail[NM];
   logic       cq_ne[NC];
   logic [4:0] cq_head[NC];
   logic [4:0] cq_tail[NC];
   logic [4:0] next_waiter[NT];
   logic       blocked[NT];

   grant_type pending_grants[$];
   grant_type pinned_grants[$];
   logic      pinned_flags[$];
   int errors = 0;
   int idle_cycles = 0;
   int hold_off = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic void enqueue_on_mutex(input int m, input logic [4:0] t);
      if (mq_ne[m]) next_waiter[mq_tail[m]] = t;
      else mq_head[m] = t;
      mq_tail[m] = t;
      mq_ne[m] = 1;
   endfunction

   function automatic void release_lock(input int m, inout grant_type g);
      logic [4:0] h;
      if (!mq_ne[m]) begin
         held[m] = 0;
         owner[m] = '0;
         return;
      end
      h = mq_head[m];
      if (h == mq_tail[m]) mq_ne[m] = 0;
      else mq_head[m] = next_waiter[h];
      owner[m] = h;
      blocked[h] = 0;
      g.woken_valid = 1;
      g.woken_thread = h;
   endfunction

   // Apply one request to the shadow tables and return its grant.
   function automatic grant_type predict_grant(input request_type r);
      grant_type g;
      int t, m, c;
      logic owns;
      logic [4:0] h;
      g = '0;
      g.status = fmcu_pkg::ST_MISUSE;
      t = r.tid;
      m = r.mid;
      c = r.cid;
      if (r.fn > fmcu_pkg::FN_BCAST || blocked[t]) return g;
      owns = held[m] && owner[m] == r.tid;
      case (r.fn)
         fmcu_pkg::FN_LOCK: begin
            if (!held[m]) begin
               held[m] = 1; owner[m] = r.tid; g.status = fmcu_pkg::ST_DONE;
            end else if (!owns) begin
               enqueue_on_mutex(m, r.tid); blocked[t] = 1;
               g.status = fmcu_pkg::ST_BLOCKED;
            end
         end
         fmcu_pkg::FN_TRYLOCK: begin
            if (!held[m]) begin
               held[m] = 1; owner[m] = r.tid; g.status = fmcu_pkg::ST_DONE;
            end else g.status = fmcu_pkg::ST_BUSY;
         end
         fmcu_pkg::FN_UNLOCK: begin
            if (owns) begin
               release_lock(m, g); g.status = fmcu_pkg::ST_DONE;
            end
         end
         fmcu_pkg::FN_WAIT: begin
            if (owns) begin
               if (cq_ne[c]) next_waiter[cq_tail[c]] = r.tid;
               else cq_head[c] = r.tid;
               cq_tail[c] = r.tid;
               cq_ne[c] = 1;
               blocked[t] = 1;
               release_lock(m, g);
               g.status = fmcu_pkg::ST_BLOCKED;
            end
         end
         fmcu_pkg::FN_SIGNAL: begin
            if (!cq_ne[c]) g.status = fmcu_pkg::ST_DONE;
            else if (owns) begin
               h = cq_head[c];
               if (h == cq_tail[c]) cq_ne[c] = 0;
               else cq_head[c] = next_waiter[h];
               enqueue_on_mutex(m, h);
               g.status = fmcu_pkg::ST_DONE;
            end
         end
         default: begin
            if (!cq_ne[c]) g.status = fmcu_pkg::ST_DONE;
            else if (owns) begin
               if (mq_ne[m]) next_waiter[mq_tail[m]] = cq_head[c];
               else mq_head[m] = cq_head[c];
               mq_tail[m] = cq_tail[c];
               mq_ne[m] = 1;
               cq_ne[c] = 0;
               g.status = fmcu_pkg::ST_DONE;
            end
         end
      endcase
      return g;
   endfunction

   // Offer one item and wait until it is taken; tvalid stays up for a following item.
   task automatic send_request(input request_type r, input logic known, input grant_type want);
      grant_type g;
      g = predict_grant(r);
      pending_grants.push_back(g);
      pinned_flags.push_back(known);
      pinned_grants.push_back(want);
      req_tdata <= r;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Idle the input for a random number of cycles, dropping tvalid when there is a gap.
   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (n > 0) req_tvalid <= 0;
      repeat (n) @(negedge clock);
   endtask

   // Build a request that tends to use the tables in well-formed ways.
   function automatic request_type pick_request(input int hot_threads, input int hot_ids);
      request_type r;
      int k;
      r.tid = 5'($urandom_range(0, hot_threads - 1));
      r.mid = 4'($urandom_range(0, hot_ids - 1));
      r.cid = 4'($urandom_range(0, hot_ids - 1));
      k = $urandom_range(0, 99);
      if (k < 3) r.fn = 3'($urandom_range(6, 7));
      else if (k < 25) r.fn = fmcu_pkg::FN_LOCK;
      else if (k < 35) r.fn = fmcu_pkg::FN_TRYLOCK;
      else if (k < 60) r.fn = fmcu_pkg::FN_UNLOCK;
      else if (k < 75) r.fn = fmcu_pkg::FN_WAIT;
      else if (k < 88) r.fn = fmcu_pkg::FN_SIGNAL;
      else r.fn = fmcu_pkg::FN_BCAST;
      // Picking the owner of a held mutex makes most requests go somewhere.
      if ($urandom_range(0, 2) != 0 && held[r.mid] && r.fn >= fmcu_pkg::FN_UNLOCK
          && r.fn <= fmcu_pkg::FN_BCAST)
         r.tid = owner[r.mid];
      if ($urandom_range(0, 15) == 0) begin
         r.tid = 5'($urandom_range(0, NT - 1));
         r.mid = 4'($urandom_range(0, NM - 1));
         r.cid = 4'($urandom_range(0, NC - 1));
      end
      return r;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      grant_type got, want;
      logic known;
      grant_type pinned;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected item", got, 0);
         end else begin
            want = pending_grants.pop_front();
            known = pinned_flags.pop_front();
            pinned = pinned_grants.pop_front();
            if (known && pinned != want)
               report_mismatch("table entry vs prediction", pinned, want);
            if (got.status != want.status) report_mismatch("status", got.status, want.status);
            if (got.woken_valid != want.woken_valid)
               report_mismatch("woken_valid", got.woken_valid, want.woken_valid);
            if (got.woken_thread != want.woken_thread)
               report_mismatch("woken_thread", got.woken_thread, want.woken_thread);
         end
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         if ($urandom_range(0, 60) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(5, 30)) @(negedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
            @(negedge clock);
         end
      end
   end

   // Directed stimulus and random traffic.
   initial begin
      row_type rows[$];
      row_type rw;
      request_type r;
      grant_type none;
      int i, w;
      none = '0;
      for (i = 0; i < NM; i++) begin held[i] = 0; owner[i] = 0; mq_ne[i] = 0; end
      for (i = 0; i < NC; i++) cq_ne[i] = 0;
      for (i = 0; i < NT; i++) blocked[i] = 0;

      // Directed table: {cid, mid, tid, fn}, pinned flag, pinned grant.
      rows.push_back('{'{4'd0, 4'd0, 5'd0, fmcu_pkg::FN_UNLOCK}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_MISUSE}});
      rows.push_back('{'{4'd15, 4'd15, 5'd31, fmcu_pkg::FN_SIGNAL}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_DONE}});
      rows.push_back('{'{4'd0, 4'd0, 5'd0, 3'd6}, 1, '{5'd0, 1'b0, fmcu_pkg::ST_MISUSE}});
      rows.push_back('{'{4'd0, 4'd0, 5'd0, 3'd7}, 1, '{5'd0, 1'b0, fmcu_pkg::ST_MISUSE}});
      rows.push_back('{'{4'd0, 4'd0, 5'd0, fmcu_pkg::FN_LOCK}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_DONE}});
      rows.push_back('{'{4'd0, 4'd0, 5'd0, fmcu_pkg::FN_LOCK}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_MISUSE}});
      rows.push_back('{'{4'd0, 4'd0, 5'd0, fmcu_pkg::FN_TRYLOCK}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_BUSY}});
      rows.push_back('{'{4'd0, 4'd0, 5'd31, fmcu_pkg::FN_TRYLOCK}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_BUSY}});
      rows.push_back('{'{4'd0, 4'd0, 5'd31, fmcu_pkg::FN_LOCK}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_BLOCKED}});
      rows.push_back('{'{4'd0, 4'd0, 5'd31, fmcu_pkg::FN_UNLOCK}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_MISUSE}});
      rows.push_back('{'{4'd0, 4'd0, 5'd5, fmcu_pkg::FN_UNLOCK}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_MISUSE}});
      rows.push_back('{'{4'd15, 4'd0, 5'd0, fmcu_pkg::FN_WAIT}, 1,
                       '{5'd31, 1'b1, fmcu_pkg::ST_BLOCKED}});
      rows.push_back('{'{4'd15, 4'd0, 5'd7, fmcu_pkg::FN_SIGNAL}, 1,
                       '{5'd0, 1'b0, fmcu_pkg::ST_MISUSE}});
      rows.push_back('{'{4'd15, 4'd0, 5'd31, fmcu_pkg::FN_SIGNAL}, 0, none});
      rows.push_back('{'{4'd0, 4'd15, 5'd31, fmcu_pkg::FN_TRYLOCK}, 0, none});
      rows.push_back('{'{4'd3, 4'd15, 5'd31, fmcu_pkg::FN_WAIT}, 0, none});
      rows.push_back('{'{4'd0, 4'd15, 5'd9, fmcu_pkg::FN_LOCK}, 0, none});
      rows.push_back('{'{4'd3, 4'd15, 5'd9, fmcu_pkg::FN_BCAST}, 0, none});
      rows.push_back('{'{4'd3, 4'd15, 5'd9, fmcu_pkg::FN_UNLOCK}, 0, none});
      rows.push_back('{'{4'd0, 4'd0, 5'd31, fmcu_pkg::FN_UNLOCK}, 0, none});
      rows.push_back('{'{4'd0, 4'd0, 5'd0, fmcu_pkg::FN_UNLOCK}, 0, none});
      rows.push_back('{'{4'd0, 4'd15, 5'd31, fmcu_pkg::FN_UNLOCK}, 0, none});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (rows[k]) begin
         rw = rows[k];
         send_request(rw.req, rw.known, rw.rsp);
         random_gap();
      end

      // Random phases: a small hot set first to build deep queues, then wider.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200) hold_off = 150;
         if (i == 400) begin
            req_tvalid <= 0;
            while (pending_grants.size() != 0) @(negedge clock);
            repeat (4) @(negedge clock);
         end
         if (i < 400) r = pick_request(6, 3);
         else r = pick_request(NT, NM);
         send_request(r, 0, none);
         if (i < 180 || i > 260) random_gap();
      end

      // Drain, then let the pipeline settle.
      req_tvalid <= 0;
      w = 0;
      while (pending_grants.size() != 0 && w < IDLE_LIMIT) begin
         @(negedge clock);
         w++;
      end
      repeat (10) @(negedge clock);
      if (errors == 0 && pending_grants.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
